### rtl/core/rrts_pkg.sv
package rrts_pkg;

  localparam int unsigned SlotCountDef = 16;

  localparam int unsigned OpcodeW = 2;
  localparam int unsigned TargetW = 4;
  localparam int unsigned StatusW = 3;
  localparam int unsigned TidW    = 4;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_FINISH = 2'd1,
    OP_SCHED  = 2'd2,
    OP_JOIN   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    RC_OK      = 3'd0,
    RC_FULL    = 3'd1,
    RC_NONE    = 3'd2,
    RC_EMPTY   = 3'd3,
    RC_NOTDONE = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    SL_EMPTY   = 2'd0,
    SL_READY   = 2'd1,
    SL_RUNNING = 2'd2,
    SL_EXITED  = 2'd3
  } slot_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CREATE,
    S_FINISH,
    S_JOIN,
    S_SCAN,
    S_OLD,
    S_NEW,
    S_DONE
  } state_e;

endpackage

### rtl/core/rrts_if.sv
interface rrts_cmd_if;
  logic                             valid;
  logic                             ready;
  logic [rrts_pkg::OpcodeW-1:0]     opcode;
  logic [rrts_pkg::TargetW-1:0]     target_id;

  modport source (output valid, output opcode, output target_id, input ready);
  modport sink   (input valid, input opcode, input target_id, output ready);
endinterface

interface rrts_res_if;
  logic                             valid;
  logic                             ready;
  logic [rrts_pkg::StatusW-1:0]     status_code;
  logic [rrts_pkg::TidW-1:0]        thread_id;
  logic                             switched;

  modport source (output valid, output status_code, output thread_id, output switched,
                  input ready);
  modport sink   (input valid, input status_code, input thread_id, input switched,
                  output ready);
endinterface

### rtl/core/round_robin_thread_slot_scheduler.sv
// Round-robin thread slot scheduler. Holds SLOT_COUNT two-bit slot states
// (empty, ready, running, exited) and the current slot; after reset slot 0
// is ready and current. Commands arrive on cmd_i (create, finish, schedule,
// join) and each yields exactly one item on res_o. One command is in work at
// a time: cmd_i.ready is high only while the sequencer is idle. All slot
// accesses go through a single read port and a single write port of the slot
// table, one slot per cycle, so the cost is set by the scan length.
// The steps: create probes slots from slot 0 upward until it finds an
// empty one or has probed all SLOT_COUNT; schedule scans up to SLOT_COUNT
// slots and, when a ready slot is found, demotes the old slot (S_OLD) and
// starts the new one (S_NEW); finish, and a join that schedules, pass
// through S_FINISH or S_JOIN ahead of the scan; a join that answers at
// once goes from S_JOIN straight to S_DONE. Every command then waits in
// S_DONE until the output register is free and hands the item to it. The
// output register lets a finished result wait while the next command is
// accepted.
module round_robin_thread_slot_scheduler #(
  parameter int unsigned SLOT_COUNT = rrts_pkg::SlotCountDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  rrts_cmd_if.sink          cmd_i,
  rrts_res_if.source        res_o
);

  localparam int unsigned IdxW = $clog2(SLOT_COUNT);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOT_COUNT - 1);

  // Slot table: flops, reset to known values, one read and one write port.
  rrts_pkg::slot_e slot_q [SLOT_COUNT];

  rrts_pkg::state_e  state_q, state_d;
  rrts_pkg::op_e     op_q, op_d;
  logic [rrts_pkg::TargetW-1:0] tgt_q, tgt_d;
  logic [IdxW-1:0]   cur_q, cur_d;
  logic [IdxW-1:0]   ptr_q, ptr_d;      // scan pointer
  logic [IdxW-1:0]   cnt_q, cnt_d;      // slots probed so far
  logic [IdxW-1:0]   found_q, found_d;  // ready slot picked by the scan

  // Result being built.
  rrts_pkg::status_e status_q, status_d;
  logic [rrts_pkg::TidW-1:0] tid_q, tid_d;
  logic              sw_q, sw_d;

  // Output register.
  logic              out_valid_q, out_valid_d;
  logic [rrts_pkg::StatusW-1:0] out_status_q, out_status_d;
  logic [rrts_pkg::TidW-1:0]    out_tid_q, out_tid_d;
  logic              out_sw_q, out_sw_d;

  // Table ports.
  logic [IdxW-1:0]   rd_addr;
  rrts_pkg::slot_e   rd_data;
  logic              wr_en;
  logic [IdxW-1:0]   wr_addr;
  rrts_pkg::slot_e   wr_data;

  logic [IdxW-1:0]   tgt_idx;
  logic              tgt_oor;
  logic [IdxW-1:0]   cur_next;
  logic [IdxW-1:0]   ptr_next;
  logic              cmd_acc;

  assign rd_data  = slot_q[rd_addr];
  assign tgt_idx  = IdxW'(tgt_q);
  assign tgt_oor  = 32'(tgt_q) >= SLOT_COUNT;
  assign cur_next = (cur_q == LastIdx) ? '0 : cur_q + 1'b1;
  assign ptr_next = (ptr_q == LastIdx) ? '0 : ptr_q + 1'b1;
  assign cmd_acc  = cmd_i.valid && cmd_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_q[i] <= (i == 0) ? rrts_pkg::SL_READY : rrts_pkg::SL_EMPTY;
      end
    end else if (wr_en) begin
      slot_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rrts_pkg::S_IDLE;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    tgt_q        <= tgt_d;
    ptr_q        <= ptr_d;
    cnt_q        <= cnt_d;
    found_q      <= found_d;
    status_q     <= status_d;
    tid_q        <= tid_d;
    sw_q         <= sw_d;
    out_status_q <= out_status_d;
    out_tid_q    <= out_tid_d;
    out_sw_q     <= out_sw_d;
  end

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    tgt_d        = tgt_q;
    cur_d        = cur_q;
    ptr_d        = ptr_q;
    cnt_d        = cnt_q;
    found_d      = found_q;
    status_d     = status_q;
    tid_d        = tid_q;
    sw_d         = sw_q;
    out_status_d = out_status_q;
    out_tid_d    = out_tid_q;
    out_sw_d     = out_sw_q;
    out_valid_d  = out_valid_q && !res_o.ready;
    rd_addr      = cur_q;
    wr_en        = 1'b0;
    wr_addr      = cur_q;
    wr_data      = rrts_pkg::SL_EMPTY;
    cmd_i.ready  = 1'b0;

    unique case (state_q)
      rrts_pkg::S_IDLE: begin
        cmd_i.ready = 1'b1;
        if (cmd_acc) begin
          op_d  = rrts_pkg::op_e'(cmd_i.opcode);
          tgt_d = cmd_i.target_id;
          sw_d  = 1'b0;
          unique case (rrts_pkg::op_e'(cmd_i.opcode))
            rrts_pkg::OP_CREATE: begin
              ptr_d   = '0;
              state_d = rrts_pkg::S_CREATE;
            end
            rrts_pkg::OP_FINISH: state_d = rrts_pkg::S_FINISH;
            rrts_pkg::OP_SCHED: begin
              ptr_d   = cur_next;
              cnt_d   = '0;
              state_d = rrts_pkg::S_SCAN;
            end
            rrts_pkg::OP_JOIN: state_d = rrts_pkg::S_JOIN;
          endcase
        end
      end

      // lowest empty slot, one probe per cycle
      rrts_pkg::S_CREATE: begin
        rd_addr = ptr_q;
        if (rd_data == rrts_pkg::SL_EMPTY) begin
          wr_en    = 1'b1;
          wr_addr  = ptr_q;
          wr_data  = rrts_pkg::SL_READY;
          status_d = rrts_pkg::RC_OK;
          tid_d    = rrts_pkg::TidW'(ptr_q);
          state_d  = rrts_pkg::S_DONE;
        end else if (ptr_q == LastIdx) begin
          status_d = rrts_pkg::RC_FULL;
          tid_d    = rrts_pkg::TidW'(cur_q);
          state_d  = rrts_pkg::S_DONE;
        end else begin
          ptr_d = ptr_next;
        end
      end

      // retire current (an empty slot holds no thread), then schedule
      rrts_pkg::S_FINISH: begin
        rd_addr = cur_q;
        if (rd_data != rrts_pkg::SL_EMPTY) begin
          wr_en   = 1'b1;
          wr_addr = cur_q;
          wr_data = rrts_pkg::SL_EXITED;
        end
        ptr_d   = cur_next;
        cnt_d   = '0;
        state_d = rrts_pkg::S_SCAN;
      end

      rrts_pkg::S_JOIN: begin
        rd_addr = tgt_idx;
        tid_d   = rrts_pkg::TidW'(cur_q);
        if (tgt_oor || rd_data == rrts_pkg::SL_EMPTY) begin
          status_d = rrts_pkg::RC_EMPTY;
          state_d  = rrts_pkg::S_DONE;
        end else if (rd_data == rrts_pkg::SL_EXITED) begin
          wr_en    = 1'b1;
          wr_addr  = tgt_idx;
          wr_data  = rrts_pkg::SL_EMPTY;
          status_d = rrts_pkg::RC_OK;
          state_d  = rrts_pkg::S_DONE;
        end else begin
          // target still alive: yield and let software retry
          ptr_d   = cur_next;
          cnt_d   = '0;
          state_d = rrts_pkg::S_SCAN;
        end
      end

      // round-robin scan from current+1, ending at current itself
      rrts_pkg::S_SCAN: begin
        rd_addr = ptr_q;
        if (rd_data == rrts_pkg::SL_READY) begin
          found_d = ptr_q;
          state_d = rrts_pkg::S_OLD;
        end else if (cnt_q == LastIdx) begin
          sw_d     = 1'b0;
          tid_d    = rrts_pkg::TidW'(cur_q);
          status_d = (op_q == rrts_pkg::OP_JOIN) ? rrts_pkg::RC_NOTDONE
                                                 : rrts_pkg::RC_NONE;
          state_d  = rrts_pkg::S_DONE;
        end else begin
          ptr_d = ptr_next;
          cnt_d = cnt_q + 1'b1;
        end
      end

      // demote old current unless it exited or is empty
      rrts_pkg::S_OLD: begin
        rd_addr = cur_q;
        if (rd_data == rrts_pkg::SL_READY || rd_data == rrts_pkg::SL_RUNNING) begin
          wr_en   = 1'b1;
          wr_addr = cur_q;
          wr_data = rrts_pkg::SL_READY;
        end
        state_d = rrts_pkg::S_NEW;
      end

      rrts_pkg::S_NEW: begin
        wr_en    = 1'b1;
        wr_addr  = found_q;
        wr_data  = rrts_pkg::SL_RUNNING;
        cur_d    = found_q;
        sw_d     = 1'b1;
        tid_d    = rrts_pkg::TidW'(found_q);
        status_d = (op_q == rrts_pkg::OP_JOIN) ? rrts_pkg::RC_NOTDONE
                                               : rrts_pkg::RC_OK;
        state_d  = rrts_pkg::S_DONE;
      end

      // hand off to the output register once it is free
      rrts_pkg::S_DONE: begin
        if (!out_valid_q || res_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = rrts_pkg::StatusW'(status_q);
          out_tid_d    = tid_q;
          out_sw_d     = sw_q;
          state_d      = rrts_pkg::S_IDLE;
        end
      end
    endcase
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.status_code = out_status_q;
  assign res_o.thread_id   = out_tid_q;
  assign res_o.switched    = out_sw_q;

  // Running-slot map for checks.
  logic [SLOT_COUNT-1:0] run_vec;
  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      run_vec[i] = (slot_q[i] == rrts_pkg::SL_RUNNING);
    end
  end

  // At most one slot runs at any time.
  a_one_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(run_vec))
    else $error("more than one running slot");

  // A running slot is always the current one.
  a_running_is_current: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (|run_vec) |-> run_vec[cur_q])
    else $error("running slot is not current");

  // An accepted command keeps the sequencer busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_acc |=> !cmd_i.ready)
    else $error("command accepted while still busy");

  // A result is loaded only when the output register can take it.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rrts_pkg::S_DONE && out_valid_q && !res_o.ready) |=>
      (state_q == rrts_pkg::S_DONE))
    else $error("pending result overwritten");

endmodule

### tb/round_robin_thread_slot_scheduler_tb.sv
`timescale 1ns / 100ps

module round_robin_thread_slot_scheduler_tb;

  localparam int unsigned SlotCount  = rrts_pkg::SlotCountDef;
  localparam int          RandomCmds = 1120;
  localparam int          DirCmds    = 27;
  localparam int          TotalCmds  = DirCmds + RandomCmds;
  // no idling on either side over the tail of the run
  localparam int          QuietTail  = 150;
  // receiver hold-off: long enough that the sequencer and output reg fill
  localparam int          HoldStart  = 300;
  localparam int          HoldCycles = 400;

  // one result item of the scheduler
  typedef struct packed {
    rrts_pkg::status_e status;
    logic [3:0]        tid;
    logic              sw;
  } thread_result_t;

  // directed row: command plus an optional hand-written expectation
  typedef struct packed {
    rrts_pkg::op_e  op;
    logic [3:0]     tgt;
    logic           typed;
    thread_result_t res;
  } cmd_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  rrts_cmd_if cmd_bus ();
  rrts_res_if res_bus ();

  round_robin_thread_slot_scheduler #(
    .SLOT_COUNT(SlotCount)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_bus),
    .res_o (res_bus)
  );

  // ---------------------------------------------------------------------
  // Scheduler model: slot table and current thread, advanced at accept.
  // ---------------------------------------------------------------------
  rrts_pkg::slot_e slot_model [SlotCount];
  logic [3:0]      cur_model;

  thread_result_t pending_results [$];

  int cmd_count;
  int mismatches;
  int gap_pct;
  int op_seen     [4];
  int status_seen [8];
  int switch_seen;

  // round-robin scan from current+1, wrapping back to current itself
  function automatic logic pick_next_thread();
    int unsigned idx;
    for (int unsigned k = 1; k <= SlotCount; k++) begin
      idx = (cur_model + k) % SlotCount;
      if (slot_model[idx] == rrts_pkg::SL_READY) begin
        // an exited or empty old current keeps its state
        if (slot_model[cur_model] == rrts_pkg::SL_READY ||
            slot_model[cur_model] == rrts_pkg::SL_RUNNING)
          slot_model[cur_model] = rrts_pkg::SL_READY;
        slot_model[idx] = rrts_pkg::SL_RUNNING;
        cur_model = 4'(idx);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic thread_result_t apply_thread_cmd(rrts_pkg::op_e op, logic [3:0] tgt);
    thread_result_t res;
    logic           found;
    res.status = rrts_pkg::RC_OK;
    res.tid    = cur_model;
    res.sw     = 1'b0;
    found      = 1'b0;
    case (op)
      rrts_pkg::OP_CREATE: begin
        res.status = rrts_pkg::RC_FULL;
        for (int i = 0; i < SlotCount; i++) begin
          if (!found && slot_model[i] == rrts_pkg::SL_EMPTY) begin
            slot_model[i] = rrts_pkg::SL_READY;
            res.status    = rrts_pkg::RC_OK;
            res.tid       = 4'(i);
            found         = 1'b1;
          end
        end
      end
      rrts_pkg::OP_FINISH: begin
        // an empty current holds no thread, so it is not marked exited
        if (slot_model[cur_model] != rrts_pkg::SL_EMPTY)
          slot_model[cur_model] = rrts_pkg::SL_EXITED;
        res.sw     = pick_next_thread();
        res.status = res.sw ? rrts_pkg::RC_OK : rrts_pkg::RC_NONE;
        res.tid    = cur_model;
      end
      rrts_pkg::OP_SCHED: begin
        res.sw     = pick_next_thread();
        res.status = res.sw ? rrts_pkg::RC_OK : rrts_pkg::RC_NONE;
        res.tid    = cur_model;
      end
      default: begin
        if (int'(tgt) >= SlotCount || slot_model[tgt] == rrts_pkg::SL_EMPTY) begin
          res.status = rrts_pkg::RC_EMPTY;
        end else if (slot_model[tgt] == rrts_pkg::SL_EXITED) begin
          // reaping works on the current slot too
          slot_model[tgt] = rrts_pkg::SL_EMPTY;
        end else begin
          // live target: schedule, software retries later
          res.sw     = pick_next_thread();
          res.status = rrts_pkg::RC_NOTDONE;
          res.tid    = cur_model;
        end
      end
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Command side. Offers one item, holds it until ready, then records the
  // expectation. A hand-written one wins over the model's for typed rows,
  // the model is advanced either way.
  // ---------------------------------------------------------------------
  task automatic offer_cmd(rrts_pkg::op_e op, logic [3:0] tgt, logic typed,
                           thread_result_t typed_res);
    thread_result_t pred;
    int             gap;
    gap = 0;
    if (cmd_count < TotalCmds - QuietTail && $urandom_range(0, 99) < gap_pct)
      gap = $urandom_range(1, 16);
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_bus.valid     <= 1'b1;
    cmd_bus.opcode    <= op;
    cmd_bus.target_id <= tgt;
    @(posedge clk_i);
    while (!cmd_bus.ready) @(posedge clk_i);
    pred = apply_thread_cmd(op, tgt);
    pending_results.push_back(typed ? typed_res : pred);
    op_seen[op]++;
    cmd_count++;
  endtask

  initial begin : stimulus
    cmd_row_t      rows [DirCmds];
    rrts_pkg::op_e op;
    logic [3:0]    tgt;
    int            mode;
    int            roll;
    int            drain_cycles;
    int            exited_slots [$];

    cmd_bus.valid     <= 1'b0;
    cmd_bus.opcode    <= rrts_pkg::OP_CREATE;
    cmd_bus.target_id <= '0;
    cmd_count   = 0;
    mismatches  = 0;
    switch_seen = 0;
    gap_pct     = 20;
    mode        = 0;
    foreach (op_seen[i]) op_seen[i] = 0;
    foreach (status_seen[i]) status_seen[i] = 0;

    // reset image: slot 0 ready and current, everything else empty
    foreach (slot_model[i]) slot_model[i] = rrts_pkg::SL_EMPTY;
    slot_model[0] = rrts_pkg::SL_READY;
    cur_model     = '0;

    // Directed walk from reset. The first part lives on slot 0 alone:
    // schedule to itself, join of an empty and of a live slot, finish with
    // nothing to run, finish of an exited current, reaping the current
    // slot, finish with an empty current. Then fill the table, overflow it,
    // and join a ready slot so that the join schedules.
    rows = '{
      '{rrts_pkg::OP_SCHED,  4'd0,  1'b1, '{rrts_pkg::RC_OK,      4'd0, 1'b1}},
      '{rrts_pkg::OP_JOIN,   4'd15, 1'b1, '{rrts_pkg::RC_EMPTY,   4'd0, 1'b0}},
      '{rrts_pkg::OP_JOIN,   4'd0,  1'b1, '{rrts_pkg::RC_NOTDONE, 4'd0, 1'b0}},
      '{rrts_pkg::OP_FINISH, 4'd9,  1'b1, '{rrts_pkg::RC_NONE,    4'd0, 1'b0}},
      '{rrts_pkg::OP_FINISH, 4'd15, 1'b1, '{rrts_pkg::RC_NONE,    4'd0, 1'b0}},
      '{rrts_pkg::OP_JOIN,   4'd0,  1'b1, '{rrts_pkg::RC_OK,      4'd0, 1'b0}},
      '{rrts_pkg::OP_FINISH, 4'd6,  1'b1, '{rrts_pkg::RC_NONE,    4'd0, 1'b0}},
      '{rrts_pkg::OP_SCHED,  4'd15, 1'b1, '{rrts_pkg::RC_NONE,    4'd0, 1'b0}},
      '{rrts_pkg::OP_CREATE, 4'd10, 1'b1, '{rrts_pkg::RC_OK,      4'd0, 1'b0}},
      '{rrts_pkg::OP_SCHED,  4'd5,  1'b1, '{rrts_pkg::RC_OK,      4'd0, 1'b1}},
      '{rrts_pkg::OP_CREATE, 4'd1,  1'b0, '{rrts_pkg::RC_OK, 4'd0, 1'b0}},
      '{rrts_pkg::OP_CREATE, 4'd2,  1'b0, '{rrts_pkg::RC_OK, 4'd0, 1'b0}},
      '{rrts_pkg::OP_CREATE, 4'd4,  1'b0, '{rrts_pkg::RC_OK, 4'd0, 1'b0}},
      '{rrts_pkg::OP_CREATE, 4'd8,  1'b0, '{rrts_pkg::RC_OK, 4'd0, 1'b0}},
      '{rrts_pkg::OP_CREATE, 4'd3,  1'b0, '{rrts_pkg::RC_OK, 4'd0, 1'b0}},
      '{rrts_pkg::OP_CREATE, 4'd12, 1'b0, '{rrts_pkg::RC_OK, 4'd0, 1'b0}},
      '{rrts_pkg::OP_CREATE, 4'd7,  1'b0, '{rrts_pkg::RC_OK, 4'd0, 1'b0}},
      '{rrts_pkg::OP_CREATE, 4'd14, 1'b0, '{rrts_pkg::RC_OK, 4'd0, 1'b0}},
      '{rrts_pkg::OP_CREATE, 4'd11, 1'b0, '{rrts_pkg::RC_OK, 4'd0, 1'b0}},
      '{rrts_pkg::OP_CREATE, 4'd13, 1'b0, '{rrts_pkg::RC_OK, 4'd0, 1'b0}},
      '{rrts_pkg::OP_CREATE, 4'd0,  1'b0, '{rrts_pkg::RC_OK, 4'd0, 1'b0}},
      '{rrts_pkg::OP_CREATE, 4'd15, 1'b0, '{rrts_pkg::RC_OK, 4'd0, 1'b0}},
      '{rrts_pkg::OP_CREATE, 4'd5,  1'b0, '{rrts_pkg::RC_OK, 4'd0, 1'b0}},
      '{rrts_pkg::OP_CREATE, 4'd6,  1'b0, '{rrts_pkg::RC_OK, 4'd0, 1'b0}},
      '{rrts_pkg::OP_CREATE, 4'd9,  1'b0, '{rrts_pkg::RC_OK, 4'd0, 1'b0}},
      '{rrts_pkg::OP_CREATE, 4'd3,  1'b1, '{rrts_pkg::RC_FULL,    4'd0, 1'b0}},
      '{rrts_pkg::OP_JOIN,   4'd5,  1'b0, '{rrts_pkg::RC_OK, 4'd0, 1'b0}}
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) offer_cmd(rows[i].op, rows[i].tgt, rows[i].typed, rows[i].res);

    // Random part in phases of 64 items. Each phase leans toward filling,
    // churning or draining the table, so full and empty tables both recur.
    for (int n = 0; n < RandomCmds; n++) begin
      if (n % 64 == 0) begin
        mode    = $urandom_range(0, 2);
        gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 60);
      end
      roll = $urandom_range(0, 99);
      case (mode)
        0:       op = (roll < 60) ? rrts_pkg::OP_CREATE :
                      (roll < 70) ? rrts_pkg::OP_FINISH :
                      (roll < 85) ? rrts_pkg::OP_SCHED  : rrts_pkg::OP_JOIN;
        1:       op = (roll < 20) ? rrts_pkg::OP_CREATE :
                      (roll < 50) ? rrts_pkg::OP_FINISH :
                      (roll < 75) ? rrts_pkg::OP_SCHED  : rrts_pkg::OP_JOIN;
        default: op = (roll < 5)  ? rrts_pkg::OP_CREATE :
                      (roll < 45) ? rrts_pkg::OP_FINISH :
                      (roll < 65) ? rrts_pkg::OP_SCHED  : rrts_pkg::OP_JOIN;
      endcase
      tgt = 4'($urandom_range(0, 15));
      if (op == rrts_pkg::OP_JOIN) begin
        // joins mostly aim at exited threads so slots get reaped
        exited_slots.delete();
        foreach (slot_model[i])
          if (slot_model[i] == rrts_pkg::SL_EXITED) exited_slots.push_back(i);
        roll = $urandom_range(0, 99);
        if (roll < 45 && exited_slots.size() > 0)
          tgt = 4'(exited_slots[$urandom_range(0, exited_slots.size() - 1)]);
        else if (roll < 60)
          tgt = cur_model;
      end
      offer_cmd(op, tgt, 1'b0, '0);
    end
    cmd_bus.valid <= 1'b0;

    // drain, then allow for a late extra item
    drain_cycles = 0;
    while (pending_results.size() != 0 && drain_cycles < 5000) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (40) @(posedge clk_i);

    if (pending_results.size() != 0) begin
      $display("%0d expected results never arrived", pending_results.size());
      mismatches += pending_results.size();
    end

    $display("Run covered %0d commands: %0d create, %0d finish, %0d schedule, %0d join.",
             cmd_count, op_seen[rrts_pkg::OP_CREATE], op_seen[rrts_pkg::OP_FINISH],
             op_seen[rrts_pkg::OP_SCHED], op_seen[rrts_pkg::OP_JOIN]);
    $display({"Statuses: %0d ok, %0d full, %0d none ready, %0d empty target, ",
              "%0d retry; %0d switches."},
             status_seen[rrts_pkg::RC_OK], status_seen[rrts_pkg::RC_FULL],
             status_seen[rrts_pkg::RC_NONE], status_seen[rrts_pkg::RC_EMPTY],
             status_seen[rrts_pkg::RC_NOTDONE], switch_seen);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // Result side. Random stall bursts whose density is redrawn every 128
  // passes of the sink loop; one long hold-off early in the random part so
  // the block backs up and drops cmd ready; no stalls over the tail.
  // ---------------------------------------------------------------------
  initial begin : result_sink
    int stall_pct;
    int sink_cycles;
    logic held_off;
    res_bus.ready <= 1'b0;
    stall_pct   = 10;
    sink_cycles = 0;
    held_off    = 1'b0;
    forever begin
      @(posedge clk_i);
      sink_cycles++;
      if (sink_cycles % 128 == 0) begin
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 6;
          default: stall_pct = 30;
        endcase
      end
      if (!held_off && cmd_count >= HoldStart) begin
        held_off = 1'b1;
        res_bus.ready <= 1'b0;
        for (int c = 0; c < HoldCycles; c++) @(posedge clk_i);
        res_bus.ready <= 1'b1;
      end else if (cmd_count < TotalCmds - QuietTail && $urandom_range(0, 99) < stall_pct) begin
        res_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
        res_bus.ready <= 1'b1;
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    thread_result_t want;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      status_seen[res_bus.status_code]++;
      if (res_bus.switched) switch_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d tid %0d switched %0d",
                   res_bus.status_code, res_bus.thread_id, res_bus.switched);
      end else begin
        want = pending_results.pop_front();
        if (res_bus.status_code != want.status || res_bus.thread_id != want.tid ||
            res_bus.switched != want.sw) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: exp status %0d tid %0d sw %0d, got %0d %0d %0d",
                     $realtime, want.status, want.tid, want.sw,
                     res_bus.status_code, res_bus.thread_id, res_bus.switched);
        end
      end
    end
  end

  // watchdog: far beyond the slowest legal run
  initial begin : watchdog
    #6_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
